[hw/rtl/kdhr_pkg.sv]
// Package for the key debounce / hold / repeat block.
// Holds key mode encoding, register indexes, reset values and the item structs.
// No dependencies.
package kdhr_pkg;

   // Key mode, also the key_state field of a result item
   typedef enum logic [1:0] {
      KEY_RELEASED = 2'd0,
      KEY_PRESSED  = 2'd1,
      KEY_HELD     = 2'd2
   } key_mode_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_LOCKOUT_MS      = 2'd0,
      CSR_HOLD_DELAY_MS   = 2'd1,
      CSR_REPEAT_INTERVAL = 2'd2,
      CSR_EVENT_ENABLE    = 2'd3
   } csr_index_type;

   localparam int unsigned CNT_W    = 16;
   localparam int unsigned EVENT_W  = 6;
   localparam int unsigned REQ_W    = 8;
   localparam int unsigned RSP_W    = 8;

   localparam logic [CNT_W-1:0]   LOCKOUT_RESET  = 16'd5;
   localparam logic [CNT_W-1:0]   HOLD_RESET     = 16'd500;
   localparam logic [CNT_W-1:0]   REPEAT_RESET   = 16'd500;
   localparam logic [EVENT_W-1:0] ENABLE_RESET   = 6'd0;
   localparam logic [CNT_W-1:0]   CNT_MAX        = 16'hFFFF;

   // Event mask bit positions
   localparam int unsigned EV_PRESSED  = 0;
   localparam int unsigned EV_CLICKED  = 1;
   localparam int unsigned EV_HELD     = 2;
   localparam int unsigned EV_REPEATED = 3;
   localparam int unsigned EV_LONG     = 4;
   localparam int unsigned EV_RELEASED = 5;

   // One tick input item
   typedef struct packed {
      logic edge_seen;
      logic level_low;
   } tick_type;

   // Configuration seen by the key logic
   typedef struct packed {
      logic [CNT_W-1:0]   lockout_ms;
      logic [CNT_W-1:0]   hold_delay_ms;
      logic [CNT_W-1:0]   repeat_interval_ms;
      logic [EVENT_W-1:0] event_enable;
   } cfg_type;

   // One result item; events indexed by the EV_* positions
   typedef struct packed {
      logic [EVENT_W-1:0] events;
      key_mode_type       key_state;
   } result_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
   endfunction

endpackage

[hw/rtl/kdhr_csr.sv]
// Configuration register file of the key debounce block.
// Depends on kdhr_pkg.
module kdhr_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_data,
   output kdhr_pkg::cfg_type      cfg
);
   import kdhr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_LOCKOUT_MS:      cfg_in.lockout_ms         = csr_data;
            CSR_HOLD_DELAY_MS:   cfg_in.hold_delay_ms      = csr_data;
            CSR_REPEAT_INTERVAL: cfg_in.repeat_interval_ms = csr_data;
            CSR_EVENT_ENABLE:    cfg_in.event_enable       = csr_data[EVENT_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lockout_ms         <= LOCKOUT_RESET;
         cfg_ff.hold_delay_ms      <= HOLD_RESET;
         cfg_ff.repeat_interval_ms <= REPEAT_RESET;
         cfg_ff.event_enable       <= ENABLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hw/rtl/kdhr_fsm.sv]
// Key state machine with lockout and press counters.
// Computes one result per tick from the current state; state advances on step.
// Depends on kdhr_pkg.
module kdhr_fsm (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  kdhr_pkg::tick_type      tick,
   input  kdhr_pkg::cfg_type       cfg,
   output kdhr_pkg::result_type    result
);
   import kdhr_pkg::*;

   key_mode_type     mode_ff,       mode_in;
   logic             lk_active_ff,  lk_active_in;
   logic [CNT_W-1:0] lk_elapsed_ff, lk_elapsed_in;
   logic [CNT_W-1:0] press_ff,      press_in;

   logic             lk_run;
   logic [CNT_W-1:0] lk_cnt;
   logic [CNT_W-1:0] press_cnt;
   logic             settled;
   logic             is_held;
   logic [CNT_W-1:0] press_limit;
   logic             press_over;
   logic [EVENT_W-1:0] ev;

   // Counters advance first, then an edge may start a lockout
   always_comb begin
      press_cnt = sat_inc(press_ff);
      lk_run    = lk_active_ff | tick.edge_seen;
      if (!lk_active_ff && tick.edge_seen) begin
         lk_cnt = '0;
      end else if (lk_active_ff) begin
         lk_cnt = sat_inc(lk_elapsed_ff);
      end else begin
         lk_cnt = lk_elapsed_ff;
      end
      settled     = lk_run && (lk_cnt > cfg.lockout_ms);
      is_held     = (mode_ff == KEY_HELD);
      press_limit = is_held ? cfg.repeat_interval_ms : cfg.hold_delay_ms;
      press_over  = press_cnt > press_limit;
   end

   // Next state
   always_comb begin
      mode_in       = mode_ff;
      lk_active_in  = lk_run;
      lk_elapsed_in = lk_cnt;
      press_in      = press_cnt;
      unique case (mode_ff)
         KEY_PRESSED, KEY_HELD: begin
            if (lk_run) begin
               if (settled) begin
                  if (!tick.level_low) begin
                     mode_in = KEY_RELEASED;
                  end
                  lk_active_in = 1'b0;
               end
            end else if (press_over) begin
               mode_in  = KEY_HELD;
               press_in = '0;
            end
         end
         default: begin
            if (settled) begin
               if (tick.level_low) begin
                  mode_in  = KEY_PRESSED;
                  press_in = '0;
               end else begin
                  mode_in = KEY_RELEASED;
               end
               lk_active_in = 1'b0;
            end
         end
      endcase
   end

   // Event outputs
   always_comb begin
      ev = '0;
      unique case (mode_ff)
         KEY_PRESSED, KEY_HELD: begin
            if (lk_run) begin
               if (settled && !tick.level_low) begin
                  ev[EV_LONG]     = is_held;
                  ev[EV_CLICKED]  = !is_held;
                  ev[EV_RELEASED] = 1'b1;
               end
            end else if (press_over) begin
               ev[EV_HELD]     = !is_held;
               ev[EV_REPEATED] = 1'b1;
            end
         end
         default: begin
            ev[EV_PRESSED] = settled && tick.level_low;
         end
      endcase
      result.key_state = mode_in;
      result.events    = ev & cfg.event_enable;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= KEY_RELEASED;
         lk_active_ff  <= 1'b0;
         lk_elapsed_ff <= '0;
         press_ff      <= '0;
      end else if (step) begin
         mode_ff       <= mode_in;
         lk_active_ff  <= lk_active_in;
         lk_elapsed_ff <= lk_elapsed_in;
         press_ff      <= press_in;
      end
   end

endmodule

[hw/rtl/key_debounce_hold_repeat_core.sv]
// Top level of the key debouncer with hold and auto-repeat.
// Instantiates kdhr_csr and kdhr_fsm; depends on kdhr_pkg.
//
// Usage:
//   req_*  : one item per millisecond tick. req_tdata[0] = pin level low
//            (pressed), req_tdata[1] = edge seen during the tick.
//   rsp_*  : one result item per tick: key state after the tick and the
//            one-tick events pressed, clicked, held, repeated, long click,
//            released, each gated by the event enable mask.
//   csr_*  : register writes, index 0 lockout, 1 hold delay, 2 repeat
//            interval, 3 event enable. Always ready; write only while idle.
// Path: a tick is held in an input register, runs through the key logic
//   and lands in the result register, which drives rsp_tvalid.
// Throughput: one tick per cycle while rsp_tready is high; the key state and
//   both counters update in the same cycle the tick leaves the input register.
// Reset: key released, no lockout, counters cleared, registers at defaults.
// Stall: while rsp_tready is low the result holds; one more tick waits in
//   the input register, then req_tready drops.
module key_debounce_hold_repeat_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] level_low, [1] edge_seen, [7:2] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [1:0] key_state, [2] pressed_event,
                                    // [3] clicked_event, [4] held_event,
                                    // [5] repeated_event, [6] long_click_event,
                                    // [7] released_event
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import kdhr_pkg::*;

   cfg_type    cfg;
   result_type result;

   logic       in_valid_ff, in_valid_in;
   tick_type   in_tick_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   logic       out_load;
   logic       step;

   kdhr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   kdhr_fsm u_fsm (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .tick   (in_tick_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Pipeline handshake: input register feeds the result register
   always_comb begin
      out_load     = !out_valid_ff || rsp_tready;
      step         = in_valid_ff && out_load;
      req_tready   = !in_valid_ff || step;
      in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !step);
      out_valid_in = step || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_tick_ff.level_low <= req_tdata[0];
         in_tick_ff.edge_seen <= req_tdata[1];
      end
      if (step) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.events, out_ff.key_state};

`ifndef SYNTHESIS
   // Each event must agree with the key state it leaves behind; a processed tick must leave a result
   a_pressed_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_ff.events[EV_PRESSED] |-> out_ff.key_state == KEY_PRESSED)
      else $error("pressed event without pressed state");
   a_release_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (out_ff.events[EV_CLICKED] || out_ff.events[EV_LONG]
                     || out_ff.events[EV_RELEASED])
      |-> out_ff.key_state == KEY_RELEASED)
      else $error("release event without released state");
   a_held_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (out_ff.events[EV_HELD] || out_ff.events[EV_REPEATED])
      |-> out_ff.key_state == KEY_HELD)
      else $error("hold or repeat event outside held state");
   a_step_fills: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_tvalid)
      else $error("processed tick left no result");
`endif

endmodule

[sim/key_debounce_hold_repeat_core_tb.sv]
// Self-checking bench for key_debounce_hold_repeat_core: button press, bounce,
// hold and auto-repeat ticks against an in-bench model of the key logic.
// Depends on kdhr_pkg and the core RTL; stands alone otherwise.
module key_debounce_hold_repeat_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kdhr_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned PHASES      = 12;
   localparam int unsigned PHASE_TICKS = 140;
   localparam int unsigned SOAK_TICKS  = 100;
   localparam int unsigned ERROR_SHOWN = 20;

   // DUT ports, all inputs known from time zero
   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [1:0]           csr_index  = CSR_LOCKOUT_MS;
   logic [15:0]          csr_data   = '0;

   // Key model: configuration and state
   logic [CNT_W-1:0]     cfg_lockout = LOCKOUT_RESET;
   logic [CNT_W-1:0]     cfg_hold    = HOLD_RESET;
   logic [CNT_W-1:0]     cfg_repeat  = REPEAT_RESET;
   logic [EVENT_W-1:0]   cfg_enable  = ENABLE_RESET;
   key_mode_type         key_st      = KEY_RELEASED;
   logic                 lock_on     = 1'b0;
   logic [CNT_W-1:0]     lock_cnt    = '0;
   logic [CNT_W-1:0]     press_cnt   = '0;

   tick_type             pending_ticks[$];
   result_type           expected_key_reports[$];

   int unsigned          send_idle_pct   = 0;
   int unsigned          recv_idle_pct   = 0;
   int unsigned          ticks_queued    = 0;
   int unsigned          ticks_sent      = 0;
   int unsigned          reports_checked = 0;
   int unsigned          events_seen     = 0;
   int unsigned          csr_writes      = 0;
   int unsigned          error_count     = 0;
   int unsigned          cycle_count     = 0;

   string                event_name[EVENT_W] = '{"pressed_event", "clicked_event",
      "held_event", "repeated_event", "long_click_event", "released_event"};

   key_debounce_hold_repeat_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [0] level_low, [1] edge_seen, [7:2] zero
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [1:0] key_state, [7:2] events pressed..released
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // One millisecond tick of the key logic; returns the report it produces
   function automatic result_type debounce_tick(input tick_type t);
      result_type         r;
      logic [EVENT_W-1:0] ev;
      logic               settled;
      logic               was_held;
      logic [CNT_W-1:0]   threshold;
      ev = '0;
      // counters advance first, both saturating
      if (lock_on && lock_cnt != CNT_MAX) lock_cnt = lock_cnt + 1'b1;
      if (press_cnt != CNT_MAX) press_cnt = press_cnt + 1'b1;
      // an edge opens a lockout unless one is already running
      if (t.edge_seen && !lock_on) begin
         lock_on  = 1'b1;
         lock_cnt = '0;
      end
      settled = lock_on && (lock_cnt > cfg_lockout);
      if (key_st == KEY_PRESSED || key_st == KEY_HELD) begin
         was_held = (key_st == KEY_HELD);
         if (lock_on) begin
            if (settled) begin
               if (!t.level_low) begin
                  ev[was_held ? EV_LONG : EV_CLICKED] = 1'b1;
                  ev[EV_RELEASED] = 1'b1;
                  key_st = KEY_RELEASED;
               end
               lock_on = 1'b0;
            end
         end else begin
            threshold = was_held ? cfg_repeat : cfg_hold;
            if (press_cnt > threshold) begin
               if (!was_held) ev[EV_HELD] = 1'b1;
               ev[EV_REPEATED] = 1'b1;
               key_st    = KEY_HELD;
               press_cnt = '0;
            end
         end
      end else if (settled) begin
         if (t.level_low) begin
            ev[EV_PRESSED] = 1'b1;
            key_st    = KEY_PRESSED;
            press_cnt = '0;
         end else begin
            key_st = KEY_RELEASED;
         end
         lock_on = 1'b0;
      end
      r.key_state = key_st;
      r.events    = ev & cfg_enable;
      return r;
   endfunction

   function automatic void note_mismatch(input string field, input int unsigned want,
                                         input int unsigned got);
      error_count++;
      if (error_count <= ERROR_SHOWN)
         $error("%s mismatch on report %0d: expected %0d, got %0d",
                field, reports_checked, want, got);
   endfunction

   // Tick driver: presents queued ticks, models the key on each accepted item
   always @(posedge clock) begin
      tick_type t;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            t = req_tdata[1:0];
            expected_key_reports.push_back(debounce_tick(t));
            ticks_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               t = pending_ticks.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {6'b0, t};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Report monitor: random back-pressure, field by field compare
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_key_reports.size() == 0) begin
               error_count++;
               if (error_count <= ERROR_SHOWN)
                  $error("report with no tick outstanding: data 0x%02h", rsp_tdata);
            end else begin
               want = expected_key_reports.pop_front();
               if (got.key_state !== want.key_state)
                  note_mismatch("key_state", want.key_state, got.key_state);
               for (int i = 0; i < EVENT_W; i++)
                  if (got.events[i] !== want.events[i])
                     note_mismatch(event_name[i], want.events[i], got.events[i]);
               if (want.events != '0) events_seen++;
               reports_checked++;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reports outstanding",
                  cycle_count, expected_key_reports.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic push_tick(input logic low, input logic edge_flag);
      tick_type t;
      t.level_low = low;
      t.edge_seen = edge_flag;
      pending_ticks.push_back(t);
      ticks_queued++;
   endtask

   // first tick carries the edge flag, the rest hold the level quietly
   task automatic push_run(input logic low, input logic edge_flag, input int unsigned n);
      push_tick(low, edge_flag);
      repeat (n - 1) push_tick(low, 1'b0);
   endtask

   // random bounce: level and edge flag both random
   task automatic push_bounce(input int unsigned max_ticks);
      repeat ($urandom_range(max_ticks))
         push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   // A press/release with bounce, a short glitch, or plain noise
   task automatic queue_button_action();
      int unsigned kind;
      kind = $urandom_range(99);
      if (kind < 15) begin
         push_bounce(6);
      end else begin
         push_tick(1'b1, 1'b1);
         push_bounce(4);
         // held low for up to 2 ticks in some actions, up to 60 in the rest
         repeat (kind < 27 ? $urandom_range(2) : $urandom_range(60)) push_tick(1'b1, 1'b0);
         push_tick(1'b0, 1'b1);
         push_bounce(4);
         repeat ($urandom_range(12)) push_tick(1'b0, 1'b0);
      end
   endtask

   // Block is idle: nothing queued, nothing in flight, pipeline flushed
   task automatic wait_drained();
      while (pending_ticks.size() != 0 || req_tvalid || expected_key_reports.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CNT_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_LOCKOUT_MS:      cfg_lockout = value;
         CSR_HOLD_DELAY_MS:   cfg_hold    = value;
         CSR_REPEAT_INTERVAL: cfg_repeat  = value;
         CSR_EVENT_ENABLE:    cfg_enable  = value[EVENT_W-1:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic csr_write_all(input logic [CNT_W-1:0] lockout, input logic [CNT_W-1:0] hold,
                                input logic [CNT_W-1:0] rep, input logic [EVENT_W-1:0] en);
      csr_write(CSR_LOCKOUT_MS, lockout);
      csr_write(CSR_HOLD_DELAY_MS, hold);
      csr_write(CSR_REPEAT_INTERVAL, rep);
      csr_write(CSR_EVENT_ENABLE, {10'b0, en});
   endtask

   // Stimulus sequence
   initial begin
      logic [CNT_W-1:0]   lockout;
      logic [CNT_W-1:0]   hold;
      logic [CNT_W-1:0]   rep;
      logic [EVENT_W-1:0] en;
      int unsigned        target;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: press settles after the default lockout, events masked
      send_idle_pct = 24;
      recv_idle_pct = 46;
      push_run(1'b1, 1'b1, 7);
      wait_drained();

      // directed: hold, repeat, ignored edges, long click, click, no-change lockout
      csr_write_all(16'd1, 16'd3, 16'd2, 6'h3F);
      push_run(1'b1, 1'b0, 4);    // turns held with first repeat
      push_run(1'b1, 1'b0, 3);    // repeat
      push_tick(1'b1, 1'b1);      // lockout while held
      push_tick(1'b0, 1'b1);      // edge inside lockout is ignored
      push_tick(1'b1, 1'b0);      // settles still low: no event
      push_run(1'b0, 1'b1, 3);    // long click and release
      push_run(1'b1, 1'b1, 3);    // press
      push_run(1'b0, 1'b1, 3);    // click and release
      push_run(1'b0, 1'b1, 3);    // settles released: no event

      // random phases: sender/receiver idling swapped, then none
      for (int ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         send_idle_pct = (ph < 4) ? 24 : (ph < 8) ? 46 : 0;
         recv_idle_pct = (ph < 4) ? 46 : (ph < 8) ? 24 : 0;
         lockout = CNT_W'($urandom_range(8));
         hold    = CNT_W'($urandom_range(30));
         rep     = CNT_W'($urandom_range(15));
         en      = ($urandom_range(3) == 0) ? EVENT_W'($urandom_range(63)) : 6'h3F;
         case (ph)
            1: begin
               lockout = '0;
               hold    = '0;
               rep     = '0;
            end
            2: en = '0;
            5: rep = CNT_MAX;       // held but never repeats
            6: hold = CNT_MAX;      // never turns held
            9: lockout = CNT_MAX;   // lockout never ends
            default: ;
         endcase
         csr_write_all(lockout, hold, rep, en);
         target = ticks_queued + PHASE_TICKS;
         while (ticks_queued < target) queue_button_action();
      end

      // long lockout: press count keeps running while a held key is locked out
      wait_drained();
      csr_write_all(16'd2, 16'd5, 16'd60, 6'h3F);
      push_run(1'b0, 1'b1, 4);    // settle to released from wherever the phases left it
      push_run(1'b1, 1'b1, 14);   // press, then held
      wait_drained();
      csr_write(CSR_LOCKOUT_MS, CNT_MAX);
      push_run(1'b1, 1'b1, SOAK_TICKS);
      wait_drained();
      csr_write(CSR_LOCKOUT_MS, '0);
      push_run(1'b1, 1'b0, 3);    // lockout clears, overdue count fires a repeat
      push_run(1'b0, 1'b1, 3);    // long click

      wait_drained();
      repeat (8) @(posedge clock);
      $display("ran %0d ticks through %0d register writes incl. extremes and a long lockout",
               ticks_sent, csr_writes);
      $display("checked %0d reports, %0d carrying events, %0d errors",
               reports_checked, events_seen, error_count);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/kdhr_pkg.sv
hw/rtl/kdhr_csr.sv
hw/rtl/kdhr_fsm.sv
hw/rtl/key_debounce_hold_repeat_core.sv
sim/key_debounce_hold_repeat_core_tb.sv
